// File: hw/rtl/smfd_pkg.sv
// Shared types, constants and the CRC-8 step function for the measurement frame decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package smfd_pkg;

  localparam logic [7:0]  CRC_POLY        = 8'h31;
  localparam logic [7:0]  CRC_INIT        = 8'hFF;
  localparam logic [15:0] CO2_LIMIT_RESET = 16'd5000;

  localparam logic [3:0]  FRAME_LAST  = 4'd8;
  localparam logic [3:0]  POS_CO2_LO  = 4'd1;
  localparam logic [3:0]  POS_TEMP_LO = 4'd4;

  localparam logic [10:0] TEMP_SCALE  = 11'd1750;
  localparam logic [11:0] TEMP_OFFSET = 12'd450;
  localparam logic [6:0]  HUM_SCALE   = 7'd100;
  localparam logic [16:0] WORD_MAX    = 17'd65535;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_CRC = 2'd1,
    STATUS_CO2 = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] co2_word;
    logic [15:0] raw_temperature;
    logic [15:0] raw_humidity;
    logic        crc_failed;
  } frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/smfd_frame_track.sv
// Byte position tracking, per-word CRC check and word assembly for one nine-byte frame.
// Depends on smfd_pkg for the CRC function, positions and the frame_t summary.
`default_nettype none

module smfd_frame_track import smfd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  output logic            at_last,
  output logic            done,
  output frame_t          frame
);

  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [15:0] co2_word, co2_word_next;
  logic [15:0] raw_temperature, raw_temperature_next;
  logic [15:0] raw_humidity, raw_humidity_next;
  logic        crc_failed, crc_failed_next;

  logic [3:0]  pos;
  logic        fail_base;
  logic        fail_now;
  logic [15:0] word;

  assign at_last = (byte_position == FRAME_LAST);

  always_comb begin
    pos = (frame_start || byte_position > FRAME_LAST) ? 4'd0 : byte_position;
    fail_base = (pos == 4'd0) ? 1'b0 : crc_failed;
    fail_now = 1'b0;
    word = {high_byte_hold, rx_byte};
    running_crc_next = running_crc;
    high_byte_hold_next = high_byte_hold;
    co2_word_next = co2_word;
    raw_temperature_next = raw_temperature;
    raw_humidity_next = raw_humidity;
    case (pos) inside
      4'd0, 4'd3, 4'd6: begin
        running_crc_next = crc8_update(CRC_INIT, rx_byte);
        high_byte_hold_next = rx_byte;
      end
      4'd1, 4'd4, 4'd7: begin
        running_crc_next = crc8_update(running_crc, rx_byte);
        if (pos == POS_CO2_LO) begin
          co2_word_next = word;
        end else if (pos == POS_TEMP_LO) begin
          raw_temperature_next = word;
        end else begin
          raw_humidity_next = word;
        end
      end
      default: begin
        fail_now = (running_crc != rx_byte);
        running_crc_next = CRC_INIT;
      end
    endcase
    if (pos < FRAME_LAST) begin
      byte_position_next = pos + 4'd1;
      crc_failed_next = fail_base | fail_now;
    end else begin
      byte_position_next = 4'd0;
      crc_failed_next = 1'b0;
    end
  end

  // The last byte only checks a CRC, so all three words are already registered.
  assign done = accept && (pos == FRAME_LAST);
  assign frame.co2_word = co2_word;
  assign frame.raw_temperature = raw_temperature;
  assign frame.raw_humidity = raw_humidity;
  assign frame.crc_failed = fail_base | fail_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 4'd0;
      running_crc <= CRC_INIT;
      high_byte_hold <= 8'd0;
      co2_word <= 16'd0;
      raw_temperature <= 16'd0;
      raw_humidity <= 16'd0;
      crc_failed <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      running_crc <= running_crc_next;
      high_byte_hold <= high_byte_hold_next;
      co2_word <= co2_word_next;
      raw_temperature <= raw_temperature_next;
      raw_humidity <= raw_humidity_next;
      crc_failed <= crc_failed_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/smfd_result.sv
// Unit conversion, plausibility status and the result output register.
// Depends on smfd_pkg for scale constants, status_t and frame_t.
`default_nettype none

module smfd_result import smfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire frame_t      frame,
  input  wire logic [15:0] co2_limit,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [15:0]      co2_ppm,
  output logic [11:0]      temp_tenths_c,
  output logic [6:0]       humidity_pct,
  output status_t          status
);

  logic [26:0] t_prod;
  logic [10:0] t_q0;
  logic [16:0] t_rem;
  logic [10:0] t_quot;
  logic [22:0] h_prod;
  logic [6:0]  h_q0;
  logic [16:0] h_rem;
  logic [6:0]  h_quot;
  logic [11:0] temp_value;
  status_t     status_value;

  // Division by 65535: x = q0 * 65535 + (low16 + q0), and that remainder stays
  // below twice the divisor, so one compare corrects the quotient.
  always_comb begin
    t_prod = 27'(frame.raw_temperature) * 27'(TEMP_SCALE);
    t_q0 = t_prod[26:16];
    t_rem = {1'b0, t_prod[15:0]} + 17'(t_q0);
    t_quot = t_q0 + ((t_rem >= WORD_MAX) ? 11'd1 : 11'd0);
    temp_value = 12'(t_quot) - TEMP_OFFSET;

    h_prod = 23'(frame.raw_humidity) * 23'(HUM_SCALE);
    h_q0 = h_prod[22:16];
    h_rem = {1'b0, h_prod[15:0]} + 17'(h_q0);
    h_quot = h_q0 + ((h_rem >= WORD_MAX) ? 7'd1 : 7'd0);

    if (frame.crc_failed) begin
      status_value = STATUS_CRC;
    end else if (frame.co2_word == 16'd0 || frame.co2_word > co2_limit) begin
      status_value = STATUS_CO2;
    end else begin
      status_value = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_value;
      if (frame.crc_failed) begin
        co2_ppm <= 16'd0;
        temp_tenths_c <= 12'd0;
        humidity_pct <= 7'd0;
      end else begin
        co2_ppm <= frame.co2_word;
        temp_tenths_c <= temp_value;
        humidity_pct <= h_quot;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sensor_measurement_frame_decoder_core.sv
// Top level of the measurement frame decoder: configuration register and channel handshakes.
// Depends on smfd_pkg, smfd_frame_track and smfd_result.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    rx_byte, frame_start
//   out       output     out_valid/out_ready  co2_ppm, temp_tenths_c, humidity_pct, status
//   cfg       input      cfg_valid/cfg_ready  cfg_data (co2_upper_limit)
//
// One byte is accepted per cycle while in_ready is high. The ninth byte of a frame loads
// the result register, which shows the result in the cycle after that byte is accepted.
// Reset clears the frame position, reinitialises the CRC and sets the CO2 limit to 5000 ppm.
// While a result waits, bytes other than the last of a frame are still accepted; the
// last byte waits until the result register is free or being emptied.
`default_nettype none

module sensor_measurement_frame_decoder_core import smfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      co2_ppm,
  output logic signed [11:0] temp_tenths_c,
  output logic [6:0]       humidity_pct,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] co2_upper_limit;
  logic        accept;
  logic        at_last;
  logic        done;
  frame_t      frame;
  logic [11:0] temp_bits;
  status_t     status_value;

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid || out_ready || !at_last;
  assign accept = in_valid && in_ready;
  assign temp_tenths_c = signed'(temp_bits);
  assign status = status_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      co2_upper_limit <= CO2_LIMIT_RESET;
    end else if (cfg_valid) begin
      co2_upper_limit <= cfg_data;
    end
  end

  smfd_frame_track u_track (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .at_last     (at_last),
    .done        (done),
    .frame       (frame)
  );

  smfd_result u_result (
    .clk           (clk),
    .rst           (rst),
    .load          (done),
    .frame         (frame),
    .co2_limit     (co2_upper_limit),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .co2_ppm       (co2_ppm),
    .temp_tenths_c (temp_bits),
    .humidity_pct  (humidity_pct),
    .status        (status_value)
  );

endmodule

`default_nettype wire
